FILE: hw/rtl/bltm_pkg.sv
`default_nettype none

package bltm_pkg;

  localparam int PROGRAM_DEPTH = 8192;
  localparam int TAPE_DEPTH    = 32768;
  localparam int STACK_DEPTH   = 1024;

  localparam int PA_W  = $clog2(PROGRAM_DEPTH);
  localparam int TA_W  = $clog2(TAPE_DEPTH);
  localparam int SA_W  = $clog2(STACK_DEPTH);
  localparam int TOP_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_FINISH = 2'd1,
    REQ_EXEC   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_CLOSE    = 2'd2,
    ERR_OPEN     = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    OP_END   = 4'd0,
    OP_RIGHT = 4'd1,
    OP_LEFT  = 4'd2,
    OP_INC   = 4'd3,
    OP_DEC   = 4'd4,
    OP_OUT   = 4'd5,
    OP_IN    = 4'd6,
    OP_OPEN  = 4'd7,
    OP_CLOSE = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WORK,
    ST_LINK
  } state_t;

  typedef struct packed {
    op_t             op;
    logic [PA_W-1:0] tgt;
  } prog_entry_t;

  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_INC   = 8'h2B;
  localparam logic [7:0] CH_DEC   = 8'h2D;
  localparam logic [7:0] CH_OUT   = 8'h2E;
  localparam logic [7:0] CH_IN    = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  function automatic op_t decode_char(input logic [7:0] c);
    op_t op;
    case (c)
      CH_RIGHT: op = OP_RIGHT;
      CH_LEFT:  op = OP_LEFT;
      CH_INC:   op = OP_INC;
      CH_DEC:   op = OP_DEC;
      CH_OUT:   op = OP_OUT;
      CH_IN:    op = OP_IN;
      CH_OPEN:  op = OP_OPEN;
      CH_CLOSE: op = OP_CLOSE;
      default:  op = OP_END;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/bltm_ram.sv
`default_nettype none

module bltm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bracket_loop_tape_machine.sv
`default_nettype none

// Channel  Dir  Fields (low bit first)
// s_*      in   tuser: req_type[1:0]; tdata: prog_char[7:0], in_byte[15:8]
// m_*      out  tdata: out_valid[0], out_byte[8:1], in_taken[9], halted[10],
//                      error_code[12:11], zero pad[15:13]
//
// Every transaction is accepted in ST_IDLE, then gets its memory data back and
// updates in ST_WORK; a matched ']' load adds ST_LINK, which links the open bracket.
// The program, tape and bracket stack each sit in a RAM with a registered read.
// After reset the tape is zeroed one cell a cycle, all TAPE_DEPTH (32768) cells,
// during which s_tready stays low.
// Input is taken only when the result register is empty or being drained.

module bracket_loop_tape_machine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // prog_char, in_byte
  input  wire logic [1:0]  s_tuser,   // req_type
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata    // out_valid, out_byte, in_taken, halted, error_code
);

  import bltm_pkg::*;

  state_t state, state_next;

  req_t       req;
  logic [7:0] pchar;
  logic [7:0] ibyte;

  logic [PA_W-1:0]  ip, ip_next;
  logic [TA_W-1:0]  cursor, cursor_next;
  logic [PA_W-1:0]  lp, lp_next;
  logic [TOP_W-1:0] top, top_next;
  logic             halt, halt_next;
  err_t             err, err_next;
  logic [TA_W-1:0]  clr_cnt, clr_cnt_next;
  logic [PA_W-1:0]  link_other, link_other_next;
  logic [PA_W-1:0]  link_pos, link_pos_next;

  logic [12:0] out_data;
  logic        res_load;
  logic        res_ov;
  logic [7:0]  res_byte;
  logic        res_taken;

  // memory ports
  logic            prog_we;
  logic [PA_W-1:0] prog_wa;
  prog_entry_t     prog_wd;
  prog_entry_t     prog_q;
  logic            tape_we;
  logic [TA_W-1:0] tape_wa;
  logic [7:0]      tape_wd;
  logic [7:0]      tape_q;
  logic            stack_we;
  logic [PA_W-1:0] stack_q;
  logic [TOP_W-1:0] top_m1;

  op_t             ld_op;
  logic [PA_W-1:0] ip_base;
  logic            accept;

  assign accept = s_tvalid && s_tready;
  assign top_m1 = top - TOP_W'(1);
  assign ld_op  = decode_char(pchar);

  bltm_ram #(.DEPTH(PROGRAM_DEPTH), .WIDTH($bits(prog_entry_t))) u_prog (
    .clk   (clk),
    .we    (prog_we),
    .waddr (prog_wa),
    .wdata (prog_wd),
    .raddr (ip),
    .rdata (prog_q)
  );

  bltm_ram #(.DEPTH(TAPE_DEPTH), .WIDTH(8)) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_wa),
    .wdata (tape_wd),
    .raddr (cursor),
    .rdata (tape_q)
  );

  bltm_ram #(.DEPTH(STACK_DEPTH), .WIDTH(PA_W)) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (top[SA_W-1:0]),
    .wdata (lp),
    .raddr (top_m1[SA_W-1:0]),
    .rdata (stack_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      ip       <= '0;
      cursor   <= '0;
      lp       <= '0;
      top      <= '0;
      halt     <= 1'b0;
      err      <= ERR_NONE;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      ip      <= ip_next;
      cursor  <= cursor_next;
      lp      <= lp_next;
      top     <= top_next;
      halt    <= halt_next;
      err     <= err_next;
      clr_cnt <= clr_cnt_next;
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req   <= req_t'(s_tuser);
      pchar <= s_tdata[7:0];
      ibyte <= s_tdata[15:8];
    end
    if (res_load) begin
      out_data <= {err_next, (halt_next || (err_next != ERR_NONE)), res_taken, res_byte, res_ov};
    end
    link_other <= link_other_next;
    link_pos   <= link_pos_next;
  end

  assign m_tdata = {3'b000, out_data};

  always_comb begin
    state_next      = state;
    ip_next         = ip;
    cursor_next     = cursor;
    lp_next         = lp;
    top_next        = top;
    halt_next       = halt;
    err_next        = err;
    clr_cnt_next    = clr_cnt;
    link_other_next = link_other;
    link_pos_next   = link_pos;
    s_tready        = 1'b0;
    res_load        = 1'b0;
    res_ov          = 1'b0;
    res_byte        = 8'd0;
    res_taken       = 1'b0;
    prog_we         = 1'b0;
    prog_wa         = lp;
    prog_wd         = '{op: OP_END, tgt: '0};
    tape_we         = 1'b0;
    tape_wa         = cursor;
    tape_wd         = tape_q;
    stack_we        = 1'b0;
    ip_base         = ip;

    case (state)
      ST_CLEAR: begin
        tape_we      = 1'b1;
        tape_wa      = clr_cnt;
        tape_wd      = 8'd0;
        clr_cnt_next = clr_cnt + TA_W'(1);
        if (clr_cnt == TA_W'(TAPE_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        s_tready = !m_tvalid || m_tready;
        if (s_tvalid && s_tready) begin
          state_next = ST_WORK;
        end
      end

      ST_WORK: begin
        state_next = ST_IDLE;
        res_load   = 1'b1;
        if (err == ERR_NONE) begin
          case (req)
            REQ_LOAD: begin
              if (ld_op != OP_END && lp < PA_W'(PROGRAM_DEPTH - 1)) begin
                case (ld_op)
                  OP_OPEN: begin
                    if (top == TOP_W'(STACK_DEPTH)) begin
                      err_next = ERR_OVERFLOW;
                    end else begin
                      stack_we = 1'b1;
                      top_next = top + TOP_W'(1);
                      prog_we  = 1'b1;
                      prog_wd  = '{op: OP_OPEN, tgt: '0};
                      lp_next  = lp + PA_W'(1);
                    end
                  end
                  OP_CLOSE: begin
                    if (top == '0) begin
                      err_next = ERR_CLOSE;
                    end else begin
                      // stack_q holds the entry at top-1: the matching open bracket
                      top_next        = top_m1;
                      prog_we         = 1'b1;
                      prog_wd         = '{op: OP_CLOSE, tgt: stack_q};
                      link_other_next = stack_q;
                      link_pos_next   = lp;
                      lp_next         = lp + PA_W'(1);
                      state_next      = ST_LINK;
                    end
                  end
                  default: begin
                    prog_we = 1'b1;
                    prog_wd = '{op: ld_op, tgt: '0};
                    lp_next = lp + PA_W'(1);
                  end
                endcase
              end
            end

            REQ_FINISH: begin
              prog_we = 1'b1;
              prog_wd = '{op: OP_END, tgt: '0};
              if (top != '0) begin
                err_next = ERR_OPEN;
              end
            end

            REQ_EXEC: begin
              if (!halt) begin
                case (prog_q.op)
                  OP_END: begin
                    halt_next = 1'b1;
                  end
                  OP_RIGHT: begin
                    cursor_next = (cursor == TA_W'(TAPE_DEPTH - 1)) ? '0
                                                                     : cursor + TA_W'(1);
                  end
                  OP_LEFT: begin
                    cursor_next = (cursor == '0) ? TA_W'(TAPE_DEPTH - 1)
                                                 : cursor - TA_W'(1);
                  end
                  OP_INC: begin
                    tape_we = 1'b1;
                    tape_wd = tape_q + 8'd1;
                  end
                  OP_DEC: begin
                    tape_we = 1'b1;
                    tape_wd = tape_q - 8'd1;
                  end
                  OP_OUT: begin
                    res_ov   = 1'b1;
                    res_byte = tape_q;
                  end
                  OP_IN: begin
                    tape_we   = 1'b1;
                    tape_wd   = ibyte;
                    res_taken = 1'b1;
                  end
                  OP_OPEN: begin
                    if (tape_q == 8'd0) begin
                      ip_base = prog_q.tgt;
                    end
                  end
                  default: begin
                    if (tape_q != 8'd0) begin
                      ip_base = prog_q.tgt;
                    end
                  end
                endcase
                if (prog_q.op != OP_END) begin
                  ip_next = (ip_base == PA_W'(PROGRAM_DEPTH - 1)) ? '0 : ip_base + PA_W'(1);
                end
              end
            end

            default: begin
            end
          endcase
        end
      end

      ST_LINK: begin
        // point the open bracket at its close
        prog_we    = 1'b1;
        prog_wa    = link_other;
        prog_wd    = '{op: OP_OPEN, tgt: link_pos};
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> !s_tready)
    else $error("input accepted during tape clear");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    err != ERR_NONE |=> err == $past(err))
    else $error("error state changed after being set");

  a_load_pos_bound: assert property (@(posedge clk) disable iff (rst)
    lp <= PA_W'(PROGRAM_DEPTH - 1))
    else $error("load position ran into the end-marker slot");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    top <= TOP_W'(STACK_DEPTH))
    else $error("bracket stack top out of range");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    accept |=> !m_tvalid)
    else $error("result register busy after accept");

endmodule

`default_nettype wire
